FILE: src/npnm_pkg.sv
// package for the negative pixel neighbor mean fix block
// types and constants used by the front, queue, back and top level
package npnm_pkg;
	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_PIXEL_BITS = 16;
	localparam int ROW_BITS = 12;
	localparam int COL_BITS = 6;
	localparam int WIDTH_REG_BITS = 7;
	localparam int HEIGHT_REG_BITS = 13;
	localparam logic [WIDTH_REG_BITS-1:0] RESET_WIDTH = 7'd5;
	localparam logic [HEIGHT_REG_BITS-1:0] RESET_HEIGHT = 13'd5;
	localparam logic [HEIGHT_REG_BITS-1:0] MAX_ROWS = 13'd4096;
	localparam int CFG_ADDR_BITS = 3;
	localparam logic [CFG_ADDR_BITS-1:0] ADDR_WIDTH = 3'd0;
	localparam logic [CFG_ADDR_BITS-1:0] ADDR_HEIGHT = 3'd4;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_EMIT
	} bk_state_t;
endpackage

FILE: src/npnm_front.sv
// front part: accepts pixels, keeps the line stores and window, classifies jobs
// depends on npnm_pkg
module npnm_front #(
	parameter int MAX_WIDTH = npnm_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = npnm_pkg::DEF_PIXEL_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [npnm_pkg::WIDTH_REG_BITS-1:0] frame_width,
	input  logic [npnm_pkg::HEIGHT_REG_BITS-1:0] frame_height,
	input  logic in_valid,
	output logic in_ready,
	input  logic [PIXEL_BITS-1:0] in_pix,
	output logic job_valid,
	input  logic job_ready,
	output logic [9*PIXEL_BITS-1:0] job_win,
	output logic [npnm_pkg::ROW_BITS-1:0] job_row,
	output logic [npnm_pkg::COL_BITS-1:0] job_col,
	output logic [2:0] job_emit,   // center, right, input
	output logic job_interior
);
	import npnm_pkg::*;
	localparam int IDX_BITS = $clog2(MAX_WIDTH);
	localparam int WC_BITS = IDX_BITS + 1;

	logic [PIXEL_BITS-1:0] older_q [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] prior_q [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] win_q [9];
	logic [COL_BITS-1:0] col_q;
	logic [ROW_BITS-1:0] row_q;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [PIXEL_BITS-1:0] old_rd_s1, pri_rd_s1;
	logic [ROW_BITS-1:0] row_s1;
	logic [COL_BITS-1:0] col_s1;
	logic lc_s1, lr_s1, int_s1;
	logic busy_q;

	logic [WC_BITS-1:0] w_eff;
	logic [HEIGHT_REG_BITS-1:0] h_eff;
	logic [WC_BITS-1:0] c_eff;
	logic [IDX_BITS-1:0] idx;
	logic last_col, last_row, interior;
	logic acc;

	always_comb begin
		if (frame_width == '0) w_eff = WC_BITS'(1);
		else if (32'(frame_width) > MAX_WIDTH) w_eff = WC_BITS'(MAX_WIDTH);
		else w_eff = WC_BITS'(frame_width);
		if (frame_height == '0) h_eff = HEIGHT_REG_BITS'(1);
		else if (frame_height > MAX_ROWS) h_eff = MAX_ROWS;
		else h_eff = frame_height;
		if (32'(col_q) >= MAX_WIDTH) c_eff = WC_BITS'(MAX_WIDTH - 1);
		else c_eff = WC_BITS'(col_q);
		idx = c_eff[IDX_BITS-1:0];
		last_col = (c_eff + WC_BITS'(1)) >= w_eff;
		last_row = ({1'b0, row_q} + 13'd1) >= h_eff;
		interior = row_q >= 12'd2 && {1'b0, row_q} < h_eff && c_eff >= WC_BITS'(2)
			&& c_eff < w_eff;
	end

	// a pixel's store reads are registered on accept; the job is built from them once the job output is free
	assign in_ready = !busy_q;
	assign acc = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (acc) begin
			old_rd_s1 <= older_q[idx];
			pri_rd_s1 <= prior_q[idx];
			older_q[idx] <= prior_q[idx];
			prior_q[idx] <= in_pix;
			pix_s1 <= in_pix;
			row_s1 <= row_q;
			col_s1 <= COL_BITS'(c_eff);
			lc_s1 <= last_col;
			lr_s1 <= last_row;
			int_s1 <= interior;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			job_valid <= 1'b0;
			col_q <= '0;
			row_q <= '0;
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else begin
			// a new job replaces the taken one while busy, so only clear when idle
			if (job_valid && job_ready && !busy_q) job_valid <= 1'b0;
			if (acc) begin
				busy_q <= 1'b1;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 12'd1;
				end else begin
					col_q <= COL_BITS'(c_eff + WC_BITS'(1));
				end
			end else if (busy_q && (!job_valid || job_ready)) begin
				busy_q <= 1'b0;
				for (int k = 0; k < 3; k++) begin
					win_q[3*k] <= win_q[3*k+1];
					win_q[3*k+1] <= win_q[3*k+2];
				end
				win_q[2] <= old_rd_s1;
				win_q[5] <= pri_rd_s1;
				win_q[8] <= pix_s1;
				job_valid <= 1'b1;
				job_row <= row_s1;
				job_col <= col_s1;
				job_interior <= int_s1;
				job_emit <= {lr_s1, row_s1 != '0 && lc_s1, row_s1 != '0 && col_s1 != '0};
				for (int k = 0; k < 9; k++) begin
					if (k == 2) job_win[k*PIXEL_BITS +: PIXEL_BITS] <= old_rd_s1;
					else if (k == 5) job_win[k*PIXEL_BITS +: PIXEL_BITS] <= pri_rd_s1;
					else if (k == 8) job_win[k*PIXEL_BITS +: PIXEL_BITS] <= pix_s1;
					else if (k % 3 == 2) job_win[k*PIXEL_BITS +: PIXEL_BITS] <= win_q[k];
					else job_win[k*PIXEL_BITS +: PIXEL_BITS] <= win_q[k+1];
				end
			end
		end
	end
endmodule

FILE: src/npnm_queue.sv
// short queue between the front and back parts
// depends on npnm_pkg for its depth
module npnm_queue #(
	parameter int DATA_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  logic [DATA_BITS-1:0] wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output logic [DATA_BITS-1:0] rd_data
);
	import npnm_pkg::*;
	logic [DATA_BITS-1:0] mem_q [QUEUE_DEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'(QUEUE_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
endmodule

FILE: src/npnm_back.sv
// back part: computes the neighbor mean and emits up to three results per job
// depends on npnm_pkg
module npnm_back #(
	parameter int PIXEL_BITS = npnm_pkg::DEF_PIXEL_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  logic [9*PIXEL_BITS-1:0] job_win,
	input  logic [npnm_pkg::ROW_BITS-1:0] job_row,
	input  logic [npnm_pkg::COL_BITS-1:0] job_col,
	input  logic [2:0] job_emit,
	input  logic job_interior,
	output logic out_valid,
	input  logic out_ready,
	output logic [PIXEL_BITS-1:0] out_pix,
	output logic [npnm_pkg::ROW_BITS-1:0] out_row,
	output logic [npnm_pkg::COL_BITS-1:0] out_col,
	output logic out_rep,
	output logic out_last
);
	import npnm_pkg::*;
	localparam int SUM_BITS = PIXEL_BITS + 3;
	// reciprocal scale wide enough that the truncated product equals sum / count
	localparam int RSH = PIXEL_BITS + 6;
	localparam int RB = RSH + 1;
	localparam int PROD_BITS = SUM_BITS + RB;
	localparam logic [RB-1:0] R1 = RB'(64'd1 << RSH);
	localparam logic [RB-1:0] R2 = RB'(64'd1 << (RSH - 1));
	localparam logic [RB-1:0] R3 = RB'(((64'd1 << RSH) + 64'd2) / 64'd3);
	localparam logic [RB-1:0] R4 = RB'(64'd1 << (RSH - 2));
	localparam logic [RB-1:0] R5 = RB'(((64'd1 << RSH) + 64'd4) / 64'd5);
	localparam logic [RB-1:0] R6 = RB'(((64'd1 << RSH) + 64'd5) / 64'd6);
	localparam logic [RB-1:0] R7 = RB'(((64'd1 << RSH) + 64'd6) / 64'd7);
	localparam logic [RB-1:0] R8 = RB'(64'd1 << (RSH - 3));

	bk_state_t state_q, state_d;
	logic [PIXEL_BITS-1:0] ctr_q, rgt_q, inp_q;
	logic [ROW_BITS-1:0] row_q;
	logic [COL_BITS-1:0] col_q;
	logic [2:0] pend_q;
	logic [SUM_BITS-1:0] sum_s1;
	logic [3:0] cnt_s1;
	logic fix_s1;
	logic [PIXEL_BITS-1:0] mean_q;
	logic rep_q;

	logic [SUM_BITS-1:0] sum_c;
	logic [3:0] cnt_c;
	logic [RB-1:0] rcp;
	logic [PROD_BITS-1:0] prod;
	logic [2:0] pend_n;
	logic take, slot_free;

	always_comb begin
		sum_c = '0;
		cnt_c = '0;
		for (int k = 0; k < 9; k++) begin
			if (!job_win[k*PIXEL_BITS+PIXEL_BITS-1] && job_win[k*PIXEL_BITS +: PIXEL_BITS] != '0)
			begin
				sum_c = sum_c + SUM_BITS'(job_win[k*PIXEL_BITS +: PIXEL_BITS]);
				cnt_c = cnt_c + 4'd1;
			end
		end
		// reciprocal of count 1..8, rounded up
		case (cnt_s1)
			4'd1: rcp = R1;
			4'd2: rcp = R2;
			4'd3: rcp = R3;
			4'd4: rcp = R4;
			4'd5: rcp = R5;
			4'd6: rcp = R6;
			4'd7: rcp = R7;
			4'd8: rcp = R8;
			default: rcp = '0;
		endcase
		prod = PROD_BITS'(sum_s1) * PROD_BITS'(rcp);
	end

	assign slot_free = !out_valid || out_ready;

	always_comb begin
		state_d = state_q;
		job_ready = 1'b0;
		take = 1'b0;
		pend_n = pend_q;
		case (state_q)
			BK_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) state_d = BK_DIV;
			end
			BK_DIV: state_d = BK_EMIT;
			BK_EMIT: begin
				if (pend_q == '0) state_d = BK_IDLE;
				else if (slot_free) begin
					take = 1'b1;
					if (pend_q[0]) pend_n = {pend_q[2:1], 1'b0};
					else if (pend_q[1]) pend_n = {pend_q[2], 2'b00};
					else pend_n = '0;
					if (pend_n == '0) state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && job_valid) begin
			ctr_q <= job_win[4*PIXEL_BITS +: PIXEL_BITS];
			rgt_q <= job_win[5*PIXEL_BITS +: PIXEL_BITS];
			inp_q <= job_win[8*PIXEL_BITS +: PIXEL_BITS];
			row_q <= job_row;
			col_q <= job_col;
			sum_s1 <= sum_c;
			cnt_s1 <= cnt_c;
			fix_s1 <= job_interior && job_win[5*PIXEL_BITS-1] && cnt_c != '0;
		end
		if (state_q == BK_DIV) begin
			mean_q <= fix_s1 ? PIXEL_BITS'(prod >> RSH) : ctr_q;
			rep_q <= fix_s1;
		end
		if (take) begin
			out_last <= pend_n == '0;
			if (pend_q[0]) begin
				out_pix <= mean_q;
				out_row <= row_q - 12'd1;
				out_col <= col_q - 6'd1;
				out_rep <= rep_q;
			end else if (pend_q[1]) begin
				out_pix <= rgt_q;
				out_row <= row_q - 12'd1;
				out_col <= col_q;
				out_rep <= 1'b0;
			end else begin
				out_pix <= inp_q;
				out_row <= row_q;
				out_col <= col_q;
				out_rep <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			pend_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_IDLE && job_valid) pend_q <= job_emit;
			else pend_q <= pend_n;
			if (take) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end
endmodule

FILE: src/negative_pixel_neighbor_mean_fix.sv
// top level: 3x3 neighbor mean fix of negative interior pixels
// front: takes a new pixel only after the previous one's job is built (line store read and write);
//   back: takes a new job only after all results of the previous one are emitted
// reset: arst_n clears counters, queue and handshakes; line stores stay unset
// registers reset to width 5 and height 5
module negative_pixel_neighbor_mean_fix #(
	parameter int MAX_WIDTH = npnm_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = npnm_pkg::DEF_PIXEL_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [npnm_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [PIXEL_BITS-1:0] s_axis_tdata,   // pixel_in
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [((PIXEL_BITS+18+7)/8)*8-1:0] m_axis_tdata, // pixel_out, out_row, out_col
	output logic m_axis_tuser,   // was_replaced
	output logic m_axis_tlast    // run_last
);
	import npnm_pkg::*;
	localparam int JOB_BITS = 9*PIXEL_BITS + ROW_BITS + COL_BITS + 4;
	localparam int TD_BITS = ((PIXEL_BITS+18+7)/8)*8;

	logic [WIDTH_REG_BITS-1:0] width_q;
	logic [HEIGHT_REG_BITS-1:0] height_q;

	// configuration writes on the access phase
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
		end else if (psel && penable && pwrite) begin
			if (paddr == ADDR_WIDTH) width_q <= pwdata[WIDTH_REG_BITS-1:0];
			else if (paddr == ADDR_HEIGHT) height_q <= pwdata[HEIGHT_REG_BITS-1:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr == ADDR_WIDTH) prdata = 32'(width_q);
		else if (paddr == ADDR_HEIGHT) prdata = 32'(height_q);
	end

	logic f_valid, f_ready, b_valid, b_ready;
	logic [JOB_BITS-1:0] f_job, b_job;
	logic [9*PIXEL_BITS-1:0] f_win;
	logic [ROW_BITS-1:0] f_row;
	logic [COL_BITS-1:0] f_col;
	logic [2:0] f_emit;
	logic f_int;
	logic [PIXEL_BITS-1:0] o_pix;
	logic [ROW_BITS-1:0] o_row;
	logic [COL_BITS-1:0] o_col;

	npnm_front #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_front (
		.clk, .arst_n, .frame_width(width_q), .frame_height(height_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_pix(s_axis_tdata),
		.job_valid(f_valid), .job_ready(f_ready), .job_win(f_win), .job_row(f_row),
		.job_col(f_col), .job_emit(f_emit), .job_interior(f_int)
	);

	assign f_job = {f_int, f_emit, f_col, f_row, f_win};

	// jobs wait here so the front keeps taking pixels while results drain
	npnm_queue #(.DATA_BITS(JOB_BITS)) u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
	);

	npnm_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
		.clk, .arst_n, .job_valid(b_valid), .job_ready(b_ready),
		.job_win(b_job[9*PIXEL_BITS-1:0]),
		.job_row(b_job[9*PIXEL_BITS +: ROW_BITS]),
		.job_col(b_job[9*PIXEL_BITS+ROW_BITS +: COL_BITS]),
		.job_emit(b_job[9*PIXEL_BITS+ROW_BITS+COL_BITS +: 3]),
		.job_interior(b_job[JOB_BITS-1]),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_pix(o_pix),
		.out_row(o_row), .out_col(o_col), .out_rep(m_axis_tuser), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = TD_BITS'({o_col, o_row, o_pix});
endmodule

FILE: src/npnm_checker.sv
// port-level checks for the negative pixel neighbor mean fix block
// bound to the top level; depends on npnm_pkg
module npnm_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic m_axis_tuser,
	input logic m_axis_tlast,
	input logic pready
);
	import npnm_pkg::*;
	// front never accepts pixels back to back
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("back to back accept");
	// stalled result holds its marks
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tlast)
		&& $stable(m_axis_tuser)) else $error("result dropped");
	a_pready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind negative_pixel_neighbor_mean_fix npnm_checker u_chk (.*);
